[rtl/core/fltpm_pkg.sv]
`default_nettype none
package fltpm_pkg;

    localparam int POOL_SLOTS    = 64;
    localparam int TABLE_ENTRIES = 512;
    localparam int MEM_DEPTH     = POOL_SLOTS * TABLE_ENTRIES;

    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W    = $clog2(POOL_SLOTS);
    localparam int ADDR_W    = SLOT_W + IDX_W;
    localparam int NFS_W     = $clog2(POOL_SLOTS + 1);

    localparam int ENTRY_W   = 52;
    localparam int VP_W      = 36;
    localparam int PF_W      = 40;
    localparam int FLAGS_W   = 12;
    localparam int CNT_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int TABLES_W  = 7;
    localparam int IN_W      = 104;
    localparam int OUT_W     = 32;
    localparam int OUT_PAD_W = OUT_W - TABLES_W - CNT_W - STATUS_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_ENABLE = 2'd1;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_MISSING   = 2'd2
    } status_t;

    typedef struct packed {
        logic       clr_wr;
        logic       load;
        logic       page_start;
        logic       rd;
        logic       eval;
        logic       leaf;
        logic       finish;
        logic [1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cnt_zero;
        logic eval_err;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[rtl/core/four_level_page_table_mapper_unit.sv]
`default_nettype none
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  request: virt_page, phys_frame, flags, page_count
// m_axis    out  m_axis_tvalid / m_axis_tready  result: status, pages_mapped, tables_used
// cfg       in   cfg_valid / cfg_ready          register index and write data
//
// after reset the table store is swept to zero, one entry a cycle, with s_axis_tready
// low (cfg writes still taken); the single write port sets the pace.
// for each page a request takes a page step, three dependent table reads, each followed
// by an evaluate step, and a leaf write; a walk that stops on an error ends the request.
// one request is in flight at a time; the next is accepted while a result waits.
// a stalled result holds m_axis and the walker waits only at its result hand-off.
module four_level_page_table_mapper_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // virt_page[35:0], phys_frame[75:36], flags[87:76], page_count[103:88]
    input  wire logic [fltpm_pkg::IN_W-1:0]          s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // status[1:0], pages_mapped[17:2], tables_used[24:18], zero[31:25]
    output logic [fltpm_pkg::OUT_W-1:0]              m_axis_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fltpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fltpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fltpm_pkg::cmd_t cmd;
    fltpm_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fltpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fltpm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

[rtl/core/fltpm_ctrl.sv]
`default_nettype none
module fltpm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fltpm_pkg::sts_t sts,
    output fltpm_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PAGE,
        S_RD,
        S_EVAL,
        S_LEAF,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic       ready_reg;
    logic [1:0] lvl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
            lvl_reg   <= fltpm_pkg::LVL_PML4;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clr_last)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid && ready_reg)
                    begin
                        state_reg <= S_PAGE;
                        ready_reg <= 1'b0;
                    end
                end
                S_PAGE:
                begin
                    lvl_reg <= fltpm_pkg::LVL_PML4;
                    if (sts.cnt_zero)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (sts.eval_err)
                        state_reg <= S_DONE;
                    else if (lvl_reg == fltpm_pkg::LVL_PD)
                        state_reg <= S_LEAF;
                    else
                    begin
                        lvl_reg   <= lvl_reg + 2'd1;
                        state_reg <= S_RD;
                    end
                end
                S_LEAF:
                begin
                    state_reg <= S_PAGE;
                end
                S_DONE:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = ready_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.clr_wr     = (state_reg == S_CLEAR);
        cmd.load       = (state_reg == S_IDLE) && in_valid && ready_reg;
        cmd.page_start = (state_reg == S_PAGE);
        cmd.rd         = (state_reg == S_RD);
        cmd.eval       = (state_reg == S_EVAL);
        cmd.leaf       = (state_reg == S_LEAF);
        cmd.finish     = (state_reg == S_DONE) && sts.out_free;
        cmd.lvl        = lvl_reg;
    end

endmodule
`default_nettype wire

[rtl/core/fltpm_dpath.sv]
`default_nettype none
module fltpm_dpath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fltpm_pkg::cmd_t                     cmd,
    output fltpm_pkg::sts_t                          sts,
    input  wire logic [fltpm_pkg::IN_W-1:0]          in_data,
    input  wire logic                                cfg_valid,
    input  wire logic [fltpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fltpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [fltpm_pkg::OUT_W-1:0]              out_data
);

    logic [fltpm_pkg::ENTRY_W-1:0] mem [fltpm_pkg::MEM_DEPTH];

    logic [fltpm_pkg::ADDR_W-1:0]   clr_cnt_reg;
    logic [fltpm_pkg::PF_W-1:0]     base_pn_reg;
    logic                           alloc_en_reg;
    logic [fltpm_pkg::NFS_W-1:0]    nfs_reg;
    logic                           out_valid_reg;

    logic [fltpm_pkg::VP_W-1:0]     vp_reg;
    logic [fltpm_pkg::PF_W-1:0]     pf_reg;
    logic [fltpm_pkg::FLAGS_W-1:0]  flags_reg;
    logic [fltpm_pkg::CNT_W-1:0]    remain_reg;
    logic [fltpm_pkg::CNT_W-1:0]    done_reg;
    fltpm_pkg::status_t             status_reg;
    logic [fltpm_pkg::SLOT_W-1:0]   slot_reg;
    logic [fltpm_pkg::ENTRY_W-1:0]  rdata_reg;
    logic [fltpm_pkg::OUT_W-1:0]    out_data_reg;

    logic [fltpm_pkg::IDX_W-1:0]    idx_sel;
    logic [fltpm_pkg::ADDR_W-1:0]   rd_addr;
    logic [fltpm_pkg::PF_W-1:0]     link_off;
    logic                           off_ok;
    logic                           alloc_do;
    logic [fltpm_pkg::SLOT_W-1:0]   child;
    fltpm_pkg::status_t             eval_code;
    logic [fltpm_pkg::ENTRY_W-1:0]  link_entry;
    logic [fltpm_pkg::ENTRY_W-1:0]  leaf_entry;
    logic                           mem_we;
    logic [fltpm_pkg::ADDR_W-1:0]   mem_waddr;
    logic [fltpm_pkg::ENTRY_W-1:0]  mem_wdata;

    // table index for the level being walked
    always_comb
    begin
        case (cmd.lvl)
            fltpm_pkg::LVL_PML4: idx_sel = vp_reg[35:27];
            fltpm_pkg::LVL_PDPT: idx_sel = vp_reg[26:18];
            fltpm_pkg::LVL_PD:   idx_sel = vp_reg[17:9];
            default:             idx_sel = vp_reg[8:0];
        endcase
    end

    assign rd_addr = {slot_reg, idx_sel};

    // slot number of a followed link, relative to the pool base
    assign link_off   = rdata_reg[fltpm_pkg::ENTRY_W-1:fltpm_pkg::FLAGS_W] - base_pn_reg;
    assign off_ok     = link_off < fltpm_pkg::PF_W'(nfs_reg);
    assign link_entry = {base_pn_reg + fltpm_pkg::PF_W'(nfs_reg), flags_reg};
    assign leaf_entry = {pf_reg, flags_reg};

    always_comb
    begin
        alloc_do  = 1'b0;
        child     = link_off[fltpm_pkg::SLOT_W-1:0];
        eval_code = fltpm_pkg::ST_OK;
        if (rdata_reg[0])
        begin
            if (!off_ok)
                eval_code = fltpm_pkg::ST_MISSING;
        end
        else if (!alloc_en_reg)
            eval_code = fltpm_pkg::ST_MISSING;
        else if (nfs_reg >= fltpm_pkg::NFS_W'(fltpm_pkg::POOL_SLOTS))
            eval_code = fltpm_pkg::ST_EXHAUSTED;
        else
        begin
            alloc_do = 1'b1;
            child    = nfs_reg[fltpm_pkg::SLOT_W-1:0];
        end
    end

    always_comb
    begin
        mem_we    = cmd.clr_wr || (cmd.eval && alloc_do) || cmd.leaf;
        mem_waddr = rd_addr;
        mem_wdata = link_entry;
        if (cmd.clr_wr)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.leaf)
        begin
            mem_waddr = {slot_reg, vp_reg[fltpm_pkg::IDX_W-1:0]};
            mem_wdata = leaf_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.rd)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            base_pn_reg   <= '0;
            alloc_en_reg  <= 1'b1;
            nfs_reg       <= fltpm_pkg::NFS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + fltpm_pkg::ADDR_W'(1);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    fltpm_pkg::CFG_TABLE_BASE:
                        base_pn_reg <= cfg_data[fltpm_pkg::CFG_DATA_W-1:fltpm_pkg::FLAGS_W];
                    fltpm_pkg::CFG_ALLOC_ENABLE:
                        alloc_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.eval && alloc_do)
                nfs_reg <= nfs_reg + fltpm_pkg::NFS_W'(1);
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vp_reg     <= in_data[35:0];
            pf_reg     <= in_data[75:36];
            flags_reg  <= in_data[87:76];
            remain_reg <= in_data[103:88];
            done_reg   <= '0;
            status_reg <= fltpm_pkg::ST_OK;
        end
        if (cmd.page_start)
            slot_reg <= '0;
        if (cmd.eval)
        begin
            if (eval_code != fltpm_pkg::ST_OK)
                status_reg <= eval_code;
            else
                slot_reg <= child;
        end
        if (cmd.leaf)
        begin
            vp_reg     <= vp_reg + fltpm_pkg::VP_W'(1);
            pf_reg     <= pf_reg + fltpm_pkg::PF_W'(1);
            done_reg   <= done_reg + fltpm_pkg::CNT_W'(1);
            remain_reg <= remain_reg - fltpm_pkg::CNT_W'(1);
        end
        if (cmd.finish)
            out_data_reg <= {{fltpm_pkg::OUT_PAD_W{1'b0}},
                             fltpm_pkg::TABLES_W'(nfs_reg), done_reg, status_reg};
    end

    always_comb
    begin
        sts          = '0;
        sts.clr_last = (clr_cnt_reg == fltpm_pkg::ADDR_W'(fltpm_pkg::MEM_DEPTH - 1));
        sts.cnt_zero = (remain_reg == '0);
        sts.eval_err = (eval_code != fltpm_pkg::ST_OK);
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[rtl/core/fltpm_chk.sv]
`default_nettype none
module fltpm_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [fltpm_pkg::OUT_W-1:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // status is a defined code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == fltpm_pkg::ST_OK)
                       || (m_axis_tdata[1:0] == fltpm_pkg::ST_EXHAUSTED)
                       || (m_axis_tdata[1:0] == fltpm_pkg::ST_MISSING))
        else $error("undefined status");

    // the root slot is always counted
    a_tables: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[24:18] != 7'd0)
        else $error("tables_used is zero");

endmodule

bind four_level_page_table_mapper_unit fltpm_chk u_fltpm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
